// ===== rtl/core/fsla_pkg.sv =====
// ----------------------------------------------------------------------------
// fsla_pkg
// Shared field types and codes of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsla_pkg;

   localparam int SLOT_W = 8;
   localparam int STAT_W = 2;
   localparam int USE_W  = 9;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [USE_W-1:0]  use_type;

   // request actions
   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // response status codes
   localparam status_type STAT_DONE        = 2'd0;
   localparam status_type STAT_EXHAUSTED   = 2'd1;
   localparam status_type STAT_BAD_RELEASE = 2'd2;

endpackage

// ===== rtl/core/fsla_ram.sv =====
// ----------------------------------------------------------------------------
// fsla_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsla_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fsla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsla_ctrl
// Sequencer of the allocator: clearing pass, head/tail/count registers,
// read-modify-write of the link and mark memories, response register.
// ----------------------------------------------------------------------------
module fsla_ctrl #(
   parameter int SLOTS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  fsla_pkg::slot_type         req_slot_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fsla_pkg::slot_type         rsp_granted_slot,
   output fsla_pkg::status_type       rsp_status,
   output fsla_pkg::use_type          rsp_slots_in_use,
   output logic                       link_wr_en,
   output logic [$clog2(SLOTS)-1:0]   link_wr_addr,
   output logic [$clog2(SLOTS)-1:0]   link_wr_data,
   output logic                       link_rd_en,
   output logic [$clog2(SLOTS)-1:0]   link_rd_addr,
   input  logic [$clog2(SLOTS)-1:0]   link_rd_data,
   output logic                       mark_wr_en,
   output logic [$clog2(SLOTS)-1:0]   mark_wr_addr,
   output logic                       mark_wr_data,
   output logic                       mark_rd_en,
   output logic [$clog2(SLOTS)-1:0]   mark_rd_addr,
   input  logic                       mark_rd_data
);
   import fsla_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS - 1);

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             op_act_ff;
   slot_type         op_idx_ff;
   logic             op_range_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   slot_type         rsp_slot_ff;
   status_type       rsp_status_ff;
   use_type          rsp_used_ff;

   logic             accept;
   logic             init_wr;
   logic             exec_go;
   logic             full;
   logic             alloc_ok;
   logic             rel_ok;
   logic [IDX_W-1:0] op_slot;
   slot_type         grant;
   status_type       status;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign init_wr   = (state_ff == ST_INIT);
   assign exec_go   = (state_ff == ST_EXEC) & (~rsp_valid_ff | rsp_ready);
   assign full      = (used_ff == FULL_CNT);
   assign op_slot   = IDX_W'(op_idx_ff);
   assign alloc_ok  = (op_act_ff == ACT_ALLOC) & ~full;
   assign rel_ok    = (op_act_ff == ACT_RELEASE) & op_range_ff & mark_rd_data;

   // both reads go out with the accepted transaction, data is back in exec
   assign link_rd_en   = accept;
   assign link_rd_addr = head_ff;
   assign mark_rd_en   = accept;
   assign mark_rd_addr = IDX_W'(req_slot_index);

   always_comb begin
      link_wr_en   = 1'b0;
      link_wr_addr = tail_ff;
      link_wr_data = op_slot;
      mark_wr_en   = 1'b0;
      mark_wr_addr = op_slot;
      mark_wr_data = 1'b0;
      if (init_wr) begin
         link_wr_en   = 1'b1;
         link_wr_addr = clr_ff;
         link_wr_data = (clr_ff == LAST_IDX) ? clr_ff : clr_ff + 1'b1;
         mark_wr_en   = 1'b1;
         mark_wr_addr = clr_ff;
      end else if (exec_go) begin
         // append at the tail only while the list is not empty
         link_wr_en   = rel_ok & ~full;
         mark_wr_en   = alloc_ok | rel_ok;
         mark_wr_addr = alloc_ok ? head_ff : op_slot;
         mark_wr_data = alloc_ok;
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      grant   = op_idx_ff;
      status  = STAT_DONE;
      if (op_act_ff == ACT_ALLOC) begin
         if (full) begin
            grant  = '0;
            status = STAT_EXHAUSTED;
         end else begin
            grant   = SLOT_W'(head_ff);
            used_in = used_ff + 1'b1;
            // head keeps its value when the last free slot goes
            if (used_ff != LAST_CNT) begin
               head_in = link_rd_data;
            end
         end
      end else begin
         if (rel_ok) begin
            if (full) begin
               head_in = op_slot;
            end
            tail_in = op_slot;
            used_in = used_ff - 1'b1;
         end else begin
            status = STAT_BAD_RELEASE;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_INIT: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign rsp_valid_in = exec_go | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= LAST_IDX;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_act_ff   <= req_action;
         op_idx_ff   <= req_slot_index;
         op_range_ff <= ({24'd0, req_slot_index} < 32'(SLOTS));
      end
      if (exec_go) begin
         rsp_slot_ff   <= grant;
         rsp_status_ff <= status;
         rsp_used_ff   <= USE_W'(used_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slots_in_use = rsp_used_ff;

endmodule

// ===== rtl/core/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Free-list slot allocator: link table and allocated marks in two RAMs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_action, req_slot_index
//  rsp      out        rsp_valid/rsp_ready   rsp_granted_slot, rsp_status,
//                                            rsp_slots_in_use
//
//  a request is accepted in the idle state, which issues the link and mark reads;
//  the exec state uses the read data and writes back head, tail and the RAMs
//  after reset a clearing pass fills every entry of both RAMs, req_ready low
//  the result sits in an output register; a new request is taken while it
//  waits, and its exec state holds until that register is free
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator #(
   parameter int SLOTS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  fsla_pkg::slot_type   req_slot_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fsla_pkg::slot_type   rsp_granted_slot,
   output fsla_pkg::status_type rsp_status,
   output fsla_pkg::use_type    rsp_slots_in_use
);
   import fsla_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   logic             link_wr_en;
   logic [IDX_W-1:0] link_wr_addr;
   logic [IDX_W-1:0] link_wr_data;
   logic             link_rd_en;
   logic [IDX_W-1:0] link_rd_addr;
   logic [IDX_W-1:0] link_rd_data;
   logic             mark_wr_en;
   logic [IDX_W-1:0] mark_wr_addr;
   logic             mark_wr_data;
   logic             mark_rd_en;
   logic [IDX_W-1:0] mark_rd_addr;
   logic             mark_rd_data;

   fsla_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_status       (rsp_status),
      .rsp_slots_in_use (rsp_slots_in_use),
      .link_wr_en       (link_wr_en),
      .link_wr_addr     (link_wr_addr),
      .link_wr_data     (link_wr_data),
      .link_rd_en       (link_rd_en),
      .link_rd_addr     (link_rd_addr),
      .link_rd_data     (link_rd_data),
      .mark_wr_en       (mark_wr_en),
      .mark_wr_addr     (mark_wr_addr),
      .mark_wr_data     (mark_wr_data),
      .mark_rd_en       (mark_rd_en),
      .mark_rd_addr     (mark_rd_addr),
      .mark_rd_data     (mark_rd_data)
   );

   fsla_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   fsla_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

endmodule

// ===== rtl/core/fsla_checker.sv =====
// ----------------------------------------------------------------------------
// fsla_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fsla_checker #(
   parameter int SLOTS = 256
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_action,
   input fsla_pkg::slot_type   req_slot_index,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fsla_pkg::slot_type   rsp_granted_slot,
   input fsla_pkg::status_type rsp_status,
   input fsla_pkg::use_type    rsp_slots_in_use
);
   import fsla_pkg::*;

   // one transaction in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // a waiting request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=>
      (req_valid && $stable(req_action) && $stable(req_slot_index)))
      else $error("waiting request changed");

   // a refused allocate only happens with the whole pool in use
   a_exhausted_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EXHAUSTED) |->
      (rsp_slots_in_use == USE_W'(SLOTS)))
      else $error("exhausted status while slots are free");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_granted_slot) && $stable(rsp_status)
       && $stable(rsp_slots_in_use)))
      else $error("stalled response changed");

endmodule

bind fixed_slot_free_list_allocator fsla_checker #(.SLOTS(SLOTS)) u_fsla_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-slot free-list allocator. A shadow free
// list predicts grant, status and in-use count for every request; responses
// are checked in order against it under random request gaps and rsp stalls.
// ----------------------------------------------------------------------------
module tb;
   import fsla_pkg::*;

   localparam int POOL        = 256;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SHOW_LIMIT  = 10;

   typedef struct {
      slot_type   slot;
      status_type status;
      use_type    count;
   } grant_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_action = ACT_ALLOC;
   slot_type   req_slot_index = '0;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   slot_type   rsp_granted_slot;
   status_type rsp_status;
   use_type    rsp_slots_in_use;

   // shadow free list
   slot_type   next_free [POOL];
   bit         taken [POOL];
   slot_type   head;
   slot_type   tail;
   use_type    in_use;

   grant_type  pending_grants[$];
   int         fail_count = 0;
   int         cycle_count = 0;
   bit         pace_on = 1'b1;

   fixed_slot_free_list_allocator #(.SLOTS(POOL)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_status       (rsp_status),
      .rsp_slots_in_use (rsp_slots_in_use)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void clear_free_list();
      for (int i = 0; i < POOL; i++) begin
         next_free[i] = slot_type'((i == POOL - 1) ? i : i + 1);
         taken[i]     = 1'b0;
      end
      head   = '0;
      tail   = slot_type'(POOL - 1);
      in_use = '0;
   endfunction

   // applies one request to the shadow list and returns the response it gives
   function automatic grant_type track_free_list(input logic act, input slot_type idx);
      grant_type r;
      slot_type  s;
      r.slot   = '0;
      r.status = STAT_DONE;
      if (act == ACT_ALLOC) begin
         if (in_use >= POOL) begin
            r.status = STAT_EXHAUSTED;
         end else begin
            s        = head;
            r.slot   = s;
            taken[s] = 1'b1;
            in_use   = in_use + 1'b1;
            // last free slot taken: head goes stale
            if (in_use < POOL) head = next_free[s];
         end
      end else begin
         r.slot = idx;
         if (!taken[idx]) begin
            r.status = STAT_BAD_RELEASE;
         end else begin
            taken[idx] = 1'b0;
            // release into an empty free list restarts it at this slot
            if (in_use >= POOL) head = idx;
            else next_free[tail] = idx;
            tail           = idx;
            next_free[idx] = idx;
            in_use         = in_use - 1'b1;
         end
      end
      r.count = in_use;
      return r;
   endfunction

   // a random slot that is currently allocated, scanning from a random start; the start itself if none is
   function automatic slot_type pick_held();
      int start;
      start = $urandom_range(0, POOL - 1);
      for (int k = 0; k < POOL; k++) begin
         if (taken[(start + k) % POOL]) return slot_type'((start + k) % POOL);
      end
      return slot_type'(start);
   endfunction

   function automatic void report_failure(input string what);
      if (fail_count < SHOW_LIMIT) $display("%0t: %s", $realtime, what);
      fail_count++;
   endfunction

   task automatic send_request(input logic act, input slot_type idx);
      @(negedge clock);
      if (pace_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_slot_index <= idx;
      do @(posedge clock); while (!req_ready);
      pending_grants.push_back(track_free_list(act, idx));
   endtask

   task automatic send_alloc();
      send_request(ACT_ALLOC, slot_type'($urandom_range(0, 255)));
   endtask

   // response side stalls in bursts
   always begin
      @(negedge clock);
      if (pace_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin : check_rsp
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            report_failure($sformatf("unexpected transaction: slot %0d status %0d count %0d",
                                     rsp_granted_slot, rsp_status, rsp_slots_in_use));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_granted_slot !== want.slot || rsp_status !== want.status ||
                rsp_slots_in_use !== want.count) begin
               report_failure($sformatf(
                  "mismatch: slot %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                  want.slot, rsp_granted_slot, want.status, rsp_status,
                  want.count, rsp_slots_in_use));
            end
         end
      end
   end

   task automatic test_corner_cases();
      send_request(ACT_RELEASE, 8'd0);     // release before anything allocated
      send_request(ACT_RELEASE, 8'd255);
      send_request(ACT_ALLOC, 8'd0);
      send_request(ACT_ALLOC, 8'd255);     // index field ignored on allocate
      send_request(ACT_ALLOC, 8'hAA);
      send_request(ACT_RELEASE, 8'd1);
      send_request(ACT_RELEASE, 8'd1);     // double release
      send_request(ACT_ALLOC, 8'h55);
      send_request(ACT_RELEASE, 8'd0);
      send_request(ACT_RELEASE, 8'hAA);
      send_request(ACT_RELEASE, 8'h55);
      send_request(ACT_RELEASE, 8'd2);
      send_request(ACT_RELEASE, 8'd3);
      send_alloc();
      send_alloc();
      send_request(ACT_RELEASE, pick_held());
      send_alloc();
   endtask

   task automatic test_pool_exhaustion();
      while (in_use < POOL) begin
         if (in_use > 0 && $urandom_range(0, 9) == 0) send_request(ACT_RELEASE, pick_held());
         else send_alloc();
      end
      repeat (3) send_alloc();             // refused while full
      send_request(ACT_RELEASE, pick_held());
      send_alloc();                        // takes the only free slot again
      send_alloc();
      repeat (3) send_request(ACT_RELEASE, pick_held());
      repeat (4) send_alloc();
   endtask

   task automatic test_drain();
      while (in_use > 0) begin
         case ($urandom_range(0, 9))
            0: send_alloc();
            1: send_request(ACT_RELEASE, slot_type'($urandom_range(0, 255)));
            default: send_request(ACT_RELEASE, pick_held());
         endcase
      end
      send_request(ACT_RELEASE, slot_type'($urandom_range(0, 255)));
      send_alloc();
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) begin
         if ($urandom_range(0, 1) == 0) send_alloc();
         else if (in_use > 0 && $urandom_range(0, 9) < 7) send_request(ACT_RELEASE, pick_held());
         else send_request(ACT_RELEASE, slot_type'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      clear_free_list();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_cases();
      test_pool_exhaustion();
      test_drain();
      test_random_mix(45);
      pace_on = 1'b0;
      test_random_mix(25);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_grants.size() == 0);
      repeat (20) @(posedge clock);
      if (pending_grants.size() != 0) report_failure("transactions still expected at end");

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
